FILE: hdl/rmc_pkg.sv
package rmc_pkg;

    // Characters kept for each text field; the output packing holds sixteen.
    localparam int FIELD_CHARS = 16;
    localparam int CIDX_W      = $clog2(FIELD_CHARS);
    localparam int OUT_CHARS   = 16;

    localparam int NUM_SLOTS  = 7;
    localparam int TEXT_SLOTS = 4;
    localparam int CHAR_SLOTS = 3;

    localparam logic [7:0] MAX_LEN_RESET = 8'd82;
    localparam logic [4:0] FLEN_MAX      = 5'(FIELD_CHARS);
    localparam logic [2:0] FIELD_NONE    = 3'd7;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Element i holds character i of the field.
    typedef logic [FIELD_CHARS-1:0][7:0] text_t;

    // Everything the result side needs from one finished sentence.
    typedef struct packed {
        logic [NUM_SLOTS-1:0]       captured;
        logic [NUM_SLOTS-1:0]       trunc;
        logic [TEXT_SLOTS-1:0][4:0] lengths;
        text_t [TEXT_SLOTS-1:0]     text;
        logic [CHAR_SLOTS-1:0][7:0] chars;
        logic [7:0]                 rx_sum;
        logic [7:0]                 calc_sum;
        logic                       sum_ok;
    } rmc_snap_t;

endpackage

FILE: hdl/rmc_parser.sv
module rmc_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_byte_in,
    input  logic [7:0]        max_len,
    input  logic              emit_busy,
    output logic              snap_valid,
    output rmc_pkg::rmc_snap_t snap
);
    import rmc_pkg::*;

    localparam logic [2:0] PH_HUNT      = 3'd0;
    localparam logic [2:0] PH_BODY      = 3'd1;
    localparam logic [2:0] PH_CKSUM     = 3'd2;
    localparam logic [2:0] PH_LF_NOSTAR = 3'd3;
    localparam logic [2:0] PH_LF_STAR   = 3'd4;

    localparam logic [2:0] PREFIX_LEN = 3'd6;
    localparam logic [7:0] PREFIX_XOR = 8'h47 ^ 8'h4E ^ 8'h52 ^ 8'h4D ^ 8'h43;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Bit 4 flags a valid hex digit, either case.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    // Fields 1 to 6 map to slots 0 to 5, field 9 to slot 6, the rest to none.
    function automatic logic [2:0] slot_of(input logic [3:0] n);
        logic [2:0] s;
        unique case (n)
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: s = 3'(n - 4'd1);
            4'd9:    s = 3'd6;
            default: s = FIELD_NONE;
        endcase
        return s;
    endfunction

    logic [2:0]                  match_reg, match_next;
    logic [2:0]                  phase_reg, phase_next;
    logic [7:0]                  xor_reg, xor_next;
    logic [7:0]                  digits_reg, digits_next;
    logic [1:0]                  hexcnt_reg, hexcnt_next;
    logic [7:0]                  slen_reg, slen_next;
    logic [3:0]                  fnum_reg, fnum_next;
    logic [4:0]                  ccnt_reg, ccnt_next;
    logic [NUM_SLOTS-1:0]        cap_reg, cap_next;
    logic [NUM_SLOTS-1:0]        trunc_reg, trunc_next;
    logic [TEXT_SLOTS-1:0][4:0]  len_reg, len_next;
    text_t [TEXT_SLOTS-1:0]      text_reg;
    logic [CHAR_SLOTS-1:0][7:0]  char_reg;

    logic       accept;
    logic       in_lf;
    logic       hunt_go;
    logic [2:0] hunt_base;
    logic [2:0] hunt_cnt;
    logic [2:0] slot;
    logic [4:0] hexv;
    logic       txt_we;
    logic       chr_we;
    logic       star;

    assign in_lf   = (phase_reg == PH_LF_NOSTAR) || (phase_reg == PH_LF_STAR);
    // Only a line feed can start a result run, so hold off just then.
    assign s_ready = !(in_lf && emit_busy);
    assign accept  = s_valid && s_ready;
    assign slot    = slot_of(fnum_reg);
    assign hexv    = hex_value(s_byte_in);

    always_comb begin
        match_next  = match_reg;
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        digits_next = digits_reg;
        hexcnt_next = hexcnt_reg;
        slen_next   = slen_reg;
        fnum_next   = fnum_reg;
        ccnt_next   = ccnt_reg;
        cap_next    = cap_reg;
        trunc_next  = trunc_reg;
        len_next    = len_reg;
        hunt_go     = 1'b0;
        hunt_base   = match_reg;
        hunt_cnt    = 3'd0;
        txt_we      = 1'b0;
        chr_we      = 1'b0;
        snap_valid  = 1'b0;

        if (accept) begin
            priority if (phase_reg == PH_HUNT) begin
                hunt_go = 1'b1;
            end else if (s_byte_in == CH_DOLLAR) begin
                hunt_go   = 1'b1;
                hunt_base = 3'd0;
            end else if (in_lf) begin
                match_next = 3'd0;
                phase_next = PH_HUNT;
                if (s_byte_in == CH_LF) begin
                    snap_valid = 1'b1;
                end else begin
                    hunt_go   = 1'b1;
                    hunt_base = 3'd0;
                end
            end else if (s_byte_in == CH_CR) begin
                phase_next = (phase_reg == PH_CKSUM) ? PH_LF_STAR : PH_LF_NOSTAR;
            end else if (slen_reg >= max_len) begin
                match_next = 3'd0;
                phase_next = PH_HUNT;
            end else begin
                slen_next = slen_reg + 8'd1;
                unique case (phase_reg)
                    PH_BODY: begin
                        if (s_byte_in == CH_STAR) begin
                            phase_next  = PH_CKSUM;
                            digits_next = 8'd0;
                            hexcnt_next = 2'd0;
                        end else begin
                            xor_next = xor_reg ^ s_byte_in;
                            if (s_byte_in == CH_COMMA) begin
                                if (slot != FIELD_NONE) begin
                                    if (!slot[0]) begin
                                        cap_next[slot] = 1'b1;
                                        if (ccnt_reg > FLEN_MAX) begin
                                            len_next[slot[2:1]] = FLEN_MAX;
                                            trunc_next[slot]    = 1'b1;
                                        end else begin
                                            len_next[slot[2:1]] = ccnt_reg;
                                        end
                                    end else if (ccnt_reg == 5'd1) begin
                                        cap_next[slot] = 1'b1;
                                    end
                                end
                                if (fnum_reg != 4'd15) begin
                                    fnum_next = fnum_reg + 4'd1;
                                end
                                ccnt_next = 5'd0;
                            end else begin
                                if (slot != FIELD_NONE) begin
                                    if (!slot[0]) begin
                                        txt_we = (ccnt_reg < FLEN_MAX);
                                    end else begin
                                        chr_we = (ccnt_reg == 5'd0);
                                    end
                                end
                                if (ccnt_reg != 5'd31) begin
                                    ccnt_next = ccnt_reg + 5'd1;
                                end
                            end
                        end
                    end
                    PH_CKSUM: begin
                        if (hexcnt_reg < 2'd2) begin
                            if (hexv[4]) begin
                                digits_next = {digits_reg[3:0], hexv[3:0]};
                                hexcnt_next = hexcnt_reg + 2'd1;
                            end else begin
                                hexcnt_next = 2'd3;
                            end
                        end
                    end
                    default: begin
                        hunt_go   = 1'b1;
                        hunt_base = 3'd0;
                    end
                endcase
            end
        end

        if (hunt_go) begin
            phase_next = PH_HUNT;
            if (hunt_base < PREFIX_LEN && s_byte_in == prefix_char(hunt_base)) begin
                hunt_cnt = hunt_base + 3'd1;
            end else begin
                hunt_cnt = (s_byte_in == CH_DOLLAR) ? 3'd1 : 3'd0;
            end
            match_next = hunt_cnt;
            if (hunt_cnt == PREFIX_LEN) begin
                match_next = 3'd0;
                if (max_len >= 8'(PREFIX_LEN)) begin
                    phase_next  = PH_BODY;
                    xor_next    = PREFIX_XOR;
                    digits_next = 8'd0;
                    hexcnt_next = 2'd0;
                    slen_next   = 8'(PREFIX_LEN);
                    fnum_next   = 4'd0;
                    ccnt_next   = 5'd0;
                    cap_next    = '0;
                    trunc_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg  <= 3'd0;
            phase_reg  <= PH_HUNT;
            xor_reg    <= 8'd0;
            digits_reg <= 8'd0;
            hexcnt_reg <= 2'd0;
            slen_reg   <= 8'd0;
            fnum_reg   <= 4'd0;
            ccnt_reg   <= 5'd0;
            cap_reg    <= '0;
            trunc_reg  <= '0;
            len_reg    <= '0;
        end else begin
            match_reg  <= match_next;
            phase_reg  <= phase_next;
            xor_reg    <= xor_next;
            digits_reg <= digits_next;
            hexcnt_reg <= hexcnt_next;
            slen_reg   <= slen_next;
            fnum_reg   <= fnum_next;
            ccnt_reg   <= ccnt_next;
            cap_reg    <= cap_next;
            trunc_reg  <= trunc_next;
            len_reg    <= len_next;
        end
    end

    // Text store: only bytes inside a captured length are ever shown.
    always_ff @(posedge aclk) begin
        if (txt_we) begin
            text_reg[slot[2:1]][ccnt_reg[CIDX_W-1:0]] <= s_byte_in;
        end
        if (chr_we) begin
            char_reg[slot[2:1]] <= s_byte_in;
        end
    end

    assign star = (phase_reg == PH_LF_STAR);

    always_comb begin
        snap.captured = cap_reg;
        snap.trunc    = trunc_reg;
        snap.lengths  = len_reg;
        snap.text     = text_reg;
        snap.chars    = char_reg;
        snap.rx_sum   = star ? digits_reg : 8'd0;
        snap.calc_sum = xor_reg;
        snap.sum_ok   = star && (digits_reg == xor_reg);
    end

endmodule

FILE: hdl/rmc_emitter.sv
module rmc_emitter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               snap_valid,
    input  rmc_pkg::rmc_snap_t snap,
    output logic               busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_field_id,
    output logic [4:0]         m_field_length,
    output logic [63:0]        m_text_head,
    output logic [63:0]        m_text_tail,
    output logic               m_truncated,
    output logic [7:0]         m_received_checksum,
    output logic [7:0]         m_computed_checksum,
    output logic               m_checksum_ok,
    output logic               m_last
);
    import rmc_pkg::*;

    rmc_snap_t hold_reg;
    logic [7:0] pend_reg;

    logic                      m_valid_reg;
    logic [2:0]                id_reg;
    logic [4:0]                flen_reg;
    logic [OUT_CHARS-1:0][7:0] out_text_reg;
    logic                      trunc_reg;
    logic [7:0]                rx_reg;
    logic [7:0]                calc_reg;
    logic                      ok_reg;
    logic                      last_reg;

    logic [2:0]                sel;
    logic [7:0]                pend_clr;
    logic                      advance;
    logic [4:0]                flen;
    logic [OUT_CHARS-1:0][7:0] out_text;
    logic                      trunc;
    text_t                     src;

    // Pending slots, bit 7 standing for the empty result.
    assign busy     = |pend_reg;
    assign pend_clr = pend_reg & (pend_reg - 8'd1);
    assign advance  = busy && (!m_valid_reg || m_ready);

    always_comb begin
        sel = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = 3'(i);
            end
        end
    end

    always_comb begin
        src      = hold_reg.text[sel[2:1]];
        out_text = '0;
        flen     = 5'd0;
        trunc    = 1'b0;
        if (sel != FIELD_NONE) begin
            trunc = hold_reg.trunc[sel];
            if (!sel[0]) begin
                flen = hold_reg.lengths[sel[2:1]];
                for (int i = 0; i < FIELD_CHARS; i++) begin
                    if (5'(i) < flen) begin
                        out_text[OUT_CHARS-1-i] = src[i];
                    end
                end
            end else begin
                flen                    = 5'd1;
                out_text[OUT_CHARS-1]   = hold_reg.chars[sel[2:1]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (snap_valid) begin
                pend_reg <= (snap.captured == '0) ? 8'h80 : {1'b0, snap.captured};
            end else if (advance) begin
                pend_reg <= pend_clr;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid) begin
            hold_reg <= snap;
        end
        if (advance) begin
            id_reg       <= sel;
            flen_reg     <= flen;
            out_text_reg <= out_text;
            trunc_reg    <= trunc;
            rx_reg       <= hold_reg.rx_sum;
            calc_reg     <= hold_reg.calc_sum;
            ok_reg       <= hold_reg.sum_ok;
            last_reg     <= (pend_clr == 8'd0);
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_field_id          = id_reg;
    assign m_field_length      = flen_reg;
    assign m_text_head         = out_text_reg[OUT_CHARS-1:OUT_CHARS/2];
    assign m_text_tail         = out_text_reg[OUT_CHARS/2-1:0];
    assign m_truncated         = trunc_reg;
    assign m_received_checksum = rx_reg;
    assign m_computed_checksum = calc_reg;
    assign m_checksum_ok       = ok_reg;
    assign m_last              = last_reg;

endmodule

FILE: hdl/nmea_rmc_sentence_parser.sv
// Channel  Direction  Handshake            Beat carries
// s_       in         s_valid / s_ready    one received byte (s_byte_in)
// m_       out        m_valid / m_ready    one captured field of a finished sentence
// cfg_     in         cfg_valid / cfg_ready  new longest accepted sentence length
//
// An accepted input beat updates the parser state at the edge where it is taken.
// The line feed closing a sentence loads the result side, which gives one result beat
// per cycle while m_ready allows (up to seven, or one empty result) from its output register.
// s_ready drops only while a previous run is still being delivered and the parser
// is waiting for a line feed; any other byte is taken at once.
// Reset (aresetn low, synchronous) returns to the prefix hunt and empties the output.
module nmea_rmc_sentence_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_field_id,
    output logic [4:0]  m_field_length,
    output logic [63:0] m_text_head,
    output logic [63:0] m_text_tail,
    output logic        m_truncated,
    output logic [7:0]  m_received_checksum,
    output logic [7:0]  m_computed_checksum,
    output logic        m_checksum_ok,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import rmc_pkg::*;

    // The length limit register. Writes are always taken; the user only
    // changes it while no sentence is in flight.
    logic [7:0] max_len_reg;

    // Hand-over between the byte parser and the result side.
    logic      snap_valid;
    rmc_snap_t snap;
    logic      emit_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    // The parser hunts for the prefix, keeps the running checksum and stores
    // the wanted fields as they stream past.
    rmc_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_in  (s_byte_in),
        .max_len    (max_len_reg),
        .emit_busy  (emit_busy),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    // The result side takes a copy of the finished sentence, so the parser can
    // carry on with the next one while results drain.
    rmc_emitter u_emitter (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .snap_valid          (snap_valid),
        .snap                (snap),
        .busy                (emit_busy),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_field_id          (m_field_id),
        .m_field_length      (m_field_length),
        .m_text_head         (m_text_head),
        .m_text_tail         (m_text_tail),
        .m_truncated         (m_truncated),
        .m_received_checksum (m_received_checksum),
        .m_computed_checksum (m_computed_checksum),
        .m_checksum_ok       (m_checksum_ok),
        .m_last              (m_last)
    );

    // A new run must never be loaded over one that is still being delivered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_valid |-> !emit_busy)
        else $error("result run loaded while previous run still pending");

    // Inside a run the results follow one another without a gap.
    a_run_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |=> m_valid)
        else $error("result run broken before its last beat");

    // The empty result stands alone and carries no text.
    a_empty_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_field_id == FIELD_NONE) |-> m_last && (m_field_length == 5'd0))
        else $error("empty result not last or not empty");

    // A good checksum flag must agree with the two checksums shown.
    a_sum_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_checksum_ok |-> (m_received_checksum == m_computed_checksum))
        else $error("checksum flag disagrees with checksums");

endmodule
